FILE: sv/lwm_pkg.sv
`default_nettype none

package lwm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  localparam logic [7:0] WILD_ONE = 8'h5F;
  localparam logic [7:0] WILD_ANY = 8'h25;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic matched;
    logic status;
  } out_t;

  typedef struct packed {
    cmd_t       op;
    logic [7:0] data;
  } op_t;

endpackage

`default_nettype wire

FILE: sv/lwm_front.sv
`default_nettype none

module lwm_front
  import lwm_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic cmd_valid,
  output logic       cmd_stall,
  input  wire  in_t  cmd_item,
  output logic       push,
  output op_t        push_op,
  input  wire  logic q_full
);

  logic hold_valid;
  op_t  hold_op;
  cmd_t kind;

  assign kind = cmd_t'(cmd_item.cmd);

  assign cmd_stall = hold_valid & q_full;
  assign push      = hold_valid & ~q_full;
  assign push_op   = hold_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!cmd_stall) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      hold_op.op   <= kind;
      hold_op.data <= cmd_item.data_byte;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lwm_queue.sv
`default_nettype none

module lwm_queue
  import lwm_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic push,
  input  wire  op_t  push_op,
  output logic       full,
  output logic       pop_valid,
  output op_t        pop_op,
  input  wire  logic pop
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lwm_back.sv
`default_nettype none

module lwm_back
  import lwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic op_valid,
  input  wire  op_t  op,
  output logic       op_pop,
  output logic       res_valid,
  input  wire  logic res_stall,
  output out_t       res_item
);

  localparam int N      = PATTERN_MAX;
  localparam int LEVELS = $clog2(N + 1);

  logic [7:0]   pat [N];
  logic [N-1:0] used;
  logic [N-1:0] used_next;
  logic         ovf;
  logic         ovf_next;
  logic [N:0]   active;
  logic [N:0]   active_next;

  logic [N-1:0] pct;
  logic [N-1:0] pct_next;
  logic [N-1:0] hit;
  logic [N-1:0] wr_en;
  logic [N-1:0] live;
  logic [N:0]   used_ext;
  logic [N:0]   len_hot;
  logic [N:0]   step;
  logic [N:0]   seed;
  logic [N:0]   tprop;
  logic [N:0]   closed;
  logic [N:0]   t_acc;
  logic         res_free;
  logic         do_op;
  logic         wild_new;

  assign res_free = ~res_valid | ~res_stall;
  assign op_pop   = op_valid & ((op.op != CMD_END) | res_free);
  assign do_op    = op_pop;
  assign wild_new = (op.data == WILD_ANY);

  assign used_ext = {used, 1'b1};
  assign len_hot  = used_ext & ~{1'b0, used};
  assign live     = active[N-1:0] & used;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      pct[i]      = (pat[i] == WILD_ANY);
      hit[i]      = (pat[i] == WILD_ONE) | (pat[i] == op.data);
      pct_next[i] = wr_en[i] ? wild_new : pct[i];
    end
  end

  assign wr_en = (do_op && op.op == CMD_APPEND) ? len_hot[N-1:0] : '0;

  always_comb begin
    used_next = used;
    ovf_next  = ovf;
    if (do_op) begin
      unique case (op.op)
        CMD_CLEAR: begin
          used_next = '0;
          ovf_next  = 1'b0;
        end
        CMD_APPEND: begin
          if (used[N-1]) begin
            ovf_next = 1'b1;
          end else begin
            used_next = used_ext[N-1:0];
          end
        end
        default: begin
          used_next = used;
        end
      endcase
    end
  end

  // one text step: percent holds its position, other lanes advance on a hit
  assign step  = {1'b0, live & pct} | {live & ~pct & hit, 1'b0};
  assign seed  = (op.op == CMD_TEXT) ? step : {{N{1'b0}}, 1'b1};
  assign tprop = {used_next & pct_next, 1'b0};

  // prefix closure over runs of percent signs
  always_comb begin
    closed = seed;
    t_acc  = tprop;
    for (int k = 0; k < LEVELS; k++) begin
      closed = closed | ((closed << (1 << k)) & t_acc);
      t_acc  = t_acc & (t_acc << (1 << k));
    end
  end

  assign active_next = do_op ? closed : active;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      ovf       <= 1'b0;
      active    <= {{N{1'b0}}, 1'b1};
      res_valid <= 1'b0;
    end else begin
      used   <= used_next;
      ovf    <= ovf_next;
      active <= active_next;
      if (do_op && op.op == CMD_END) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_op && op.op == CMD_END) begin
      res_item.matched <= ~ovf & (|(active & len_hot));
      res_item.status  <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (wr_en[i]) begin
        pat[i] <= op.data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/like_wildcard_match.sv
// SQL LIKE matcher with a streamed pattern and streamed text.
// cmd channel (cmd_valid / cmd_stall / cmd_item): one transaction per
// command: clear pattern, append pattern byte, text byte, end of text.
// res channel (res_valid / res_stall / res_item): one transaction for
// each end of text, carrying matched and status (1 = pattern overflow).
// Underscore matches any one byte, percent any run of bytes, others
// match exactly. Patterns longer than PATTERN_MAX bytes set overflow.
// Throughput: one command per cycle sustained while res_stall is low;
// each command, text bytes included, is applied by the back end with a
// bit-parallel position update and a log-depth percent closure.
// Path: a command is registered by the front end, passes a two-entry
// queue and is applied by the back end; each result is held in a
// result register when its end-of-text command is applied.
// When res_stall is high the result register holds; the queue keeps
// taking commands that produce no result, then fills and cmd_stall rises.
// Reset (rst, synchronous) empties the pattern, clears overflow, arms
// position zero and drops all pending transactions.
`default_nettype none

module like_wildcard_match
  import lwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic cmd_valid,
  output logic       cmd_stall,
  input  wire  in_t  cmd_item,
  output logic       res_valid,
  input  wire  logic res_stall,
  output out_t       res_item
);

  logic push;
  op_t  push_op;
  logic q_full;
  logic pop_valid;
  op_t  pop_op;
  logic pop;

  lwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .push      (push),
    .push_op   (push_op),
    .q_full    (q_full)
  );

  lwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop       (pop)
  );

  lwm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (pop_valid),
    .op        (pop_op),
    .op_pop    (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

FILE: tb/like_wildcard_match_checker.sv
module like_wildcard_match_checker
  import lwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire logic cmd_stall,
  input  wire in_t  cmd_item,
  input  wire logic res_valid,
  input  wire logic res_stall,
  input  wire out_t res_item,
  output int        mismatch_count,
  output int        pending
);

  logic [7:0]         pat_bytes [PATTERN_MAX];
  int                 pat_len = 0;
  logic               pat_over = 1'b0;
  logic [PATTERN_MAX:0] live_pos = {{PATTERN_MAX{1'b0}}, 1'b1};
  out_t               expected_verdicts [$];
  int                 fails = 0;
  int                 outstanding = 0;

  assign mismatch_count = fails;
  assign pending = outstanding;

  // a live percent also makes the position after it live
  function automatic logic [PATTERN_MAX:0] follow_percent(input logic [PATTERN_MAX:0] s);
    logic [PATTERN_MAX:0] r;
    r = s;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat_bytes[i] == WILD_ANY) r[i + 1] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [PATTERN_MAX:0] fresh_positions();
    return follow_percent({{PATTERN_MAX{1'b0}}, 1'b1});
  endfunction

  function automatic logic [PATTERN_MAX:0] advance_positions(input logic [7:0] b);
    logic [PATTERN_MAX:0] nxt;
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live_pos[i]) begin
        if (pat_bytes[i] == WILD_ANY) nxt[i] = 1'b1;
        else if (pat_bytes[i] == WILD_ONE || pat_bytes[i] == b) nxt[i + 1] = 1'b1;
      end
    end
    return follow_percent(nxt);
  endfunction

  task automatic apply_cmd(input in_t t);
    out_t v;
    case (cmd_t'(t.cmd))
      CMD_CLEAR: begin
        pat_len = 0;
        pat_over = 1'b0;
        live_pos = fresh_positions();
      end
      CMD_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = t.data_byte;
          pat_len++;
        end else begin
          pat_over = 1'b1;
        end
        live_pos = fresh_positions();
      end
      CMD_TEXT: begin
        live_pos = advance_positions(t.data_byte);
      end
      CMD_END: begin
        v.matched = !pat_over && live_pos[pat_len];
        v.status = pat_over;
        expected_verdicts.insert(expected_verdicts.size(), v);
        live_pos = fresh_positions();
      end
    endcase
  endtask

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      pat_len = 0;
      pat_over = 1'b0;
      live_pos = fresh_positions();
      expected_verdicts.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected result transaction matched=%0b status=%0b",
                                 res_item.matched, res_item.status));
        end else begin
          want = expected_verdicts.pop_front();
          if (res_item.matched !== want.matched || res_item.status !== want.status) begin
            note_failure($sformatf("expected matched=%0b status=%0b, got matched=%0b status=%0b",
                                   want.matched, want.status,
                                   res_item.matched, res_item.status));
          end
        end
      end
      if (cmd_valid && !cmd_stall) apply_cmd(cmd_item);
    end
    outstanding <= expected_verdicts.size();
  end

endmodule

FILE: tb/like_wildcard_match_tb.sv
module like_wildcard_match_tb;
  import lwm_pkg::*;

  localparam int PATTERN_MAX = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  in_t  cmd_item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res_item;

  int mismatch_count;
  int pending;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic [7:0] cur_pattern [$];

  like_wildcard_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  like_wildcard_match_checker #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd_item      (cmd_item),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_item      (res_item),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver back-pressure, in one of four randomly chosen modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      2: res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= ((stall_left % 8) < 3);
    endcase
  end

  task automatic send_cmd(input cmd_t op, input logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    cmd_item <= '{cmd: op, data_byte: d};
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 1) == 0) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1: return WILD_ANY;
      2, 3: return WILD_ONE;
      4, 5, 6: return 8'(8'h61 + $urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b);
    if (cur_pattern.size() < PATTERN_MAX) cur_pattern.insert(cur_pattern.size(), b);
    send_cmd(CMD_APPEND, b);
  endtask

  task automatic load_pattern(input int len);
    cur_pattern.delete();
    send_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)));
    repeat (len) append_byte(pick_pattern_byte());
  endtask

  // text built to fit the current pattern, then maybe damaged
  task automatic send_text(input bit mutate);
    logic [7:0] txt [$];
    int idx;
    foreach (cur_pattern[i]) begin
      if (cur_pattern[i] == WILD_ANY) begin
        repeat ($urandom_range(0, 3)) txt.insert(txt.size(), filler_byte());
      end else if (cur_pattern[i] == WILD_ONE) begin
        txt.insert(txt.size(), 8'($urandom_range(0, 255)));
      end else begin
        txt.insert(txt.size(), cur_pattern[i]);
      end
    end
    if (mutate) begin
      idx = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 2))
        0: if (txt.size() > 0) txt[idx] = filler_byte();
        1: if (txt.size() > 0) txt.delete(idx);
        default: txt.insert(idx, filler_byte());
      endcase
    end
    foreach (txt[i]) send_cmd(CMD_TEXT, txt[i]);
    send_cmd(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int n;
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty pattern against empty and non-empty text
    send_cmd(CMD_END, 8'h00);
    send_cmd(CMD_TEXT, 8'h00);
    send_cmd(CMD_END, 8'hFF);
    // lone percent, also against a percent in the text
    send_cmd(CMD_CLEAR, 8'hFF);
    send_cmd(CMD_APPEND, WILD_ANY);
    send_cmd(CMD_END, 8'h00);
    send_cmd(CMD_TEXT, WILD_ANY);
    send_cmd(CMD_TEXT, 8'hFF);
    send_cmd(CMD_END, 8'h00);
    // case sensitivity
    send_cmd(CMD_APPEND, 8'h61);
    send_cmd(CMD_TEXT, 8'h41);
    send_cmd(CMD_END, 8'h00);
    // underscore, extreme bytes, append in the middle of a text
    send_cmd(CMD_CLEAR, 8'h00);
    send_cmd(CMD_APPEND, WILD_ONE);
    send_cmd(CMD_APPEND, 8'hFF);
    send_cmd(CMD_TEXT, 8'h71);
    send_cmd(CMD_APPEND, 8'h00);
    send_cmd(CMD_TEXT, 8'h78);
    send_cmd(CMD_TEXT, 8'hFF);
    send_cmd(CMD_TEXT, 8'h00);
    send_cmd(CMD_END, 8'h00);
    send_cmd(CMD_TEXT, WILD_ONE);
    send_cmd(CMD_END, 8'hFF);
    wait_idle();

    n = 0;
    while (items_sent < 1030) begin
      if (n == 0) len = PATTERN_MAX;
      else if (n == 1) len = PATTERN_MAX + 1;
      else begin
        case ($urandom_range(0, 19))
          0: len = 0;
          1: len = PATTERN_MAX;
          2: len = PATTERN_MAX + $urandom_range(1, 3);
          default: len = $urandom_range(1, 8);
        endcase
      end
      if (n > 1 && $urandom_range(0, 9) == 0) begin
        repeat (8) send_cmd(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        load_pattern(len);
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 19) == 0) append_byte(pick_pattern_byte());
          send_text($urandom_range(0, 3) == 0);
        end
      end
      if (n == 20) wait_idle();
      n++;
    end

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/lwm_pkg.sv
sv/lwm_front.sv
sv/lwm_queue.sv
sv/lwm_back.sv
sv/like_wildcard_match.sv
tb/like_wildcard_match_checker.sv
tb/like_wildcard_match_tb.sv
